// ===== rtl/core/aod_pkg.sv =====
// Shared constants and types for the optical density pixel core.
// No dependencies.
package aod_pkg;

    localparam int PIX_PORT_W = 16;
    localparam int OD_W       = 16;
    localparam int DISP_W     = 8;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int LOG_FRAC   = 28;
    localparam int MANT_W     = 32;
    localparam int QBITS      = 8;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic signed [CFG_W-1:0] RAIL_DOWN_RST = 16'sd0;
    localparam logic signed [CFG_W-1:0] RAIL_UP_RST   = 16'sd2048;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RAIL_DOWN = 8'd0,
        REG_RAIL_UP   = 8'd1
    } cfg_reg_t;

endpackage

// ===== rtl/core/absorption_optical_density_pixel_core.sv =====
// Optical density pixel core: od = ln((beam-back)/(atom-back)) and display byte.
// Depends on aod_pkg.
// One pixel per cycle sustained while the output is not stalled.
// The 28 squaring stages of the log2 units and the 8 quotient stages set the depth.
// Reset (aresetn low, synchronous) clears all stage valid bits and loads the rails.
`default_nettype none
module absorption_optical_density_pixel_core #(
    parameter int PIXEL_BITS   = 16,
    parameter int OD_FRAC_BITS = 11
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // config write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [aod_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [aod_pkg::CFG_W-1:0]         cfg_wdata,
    // pixel triple in
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [aod_pkg::PIX_PORT_W-1:0]    s_atom_pixel,
    input  wire logic [aod_pkg::PIX_PORT_W-1:0]    s_beam_pixel,
    input  wire logic [aod_pkg::PIX_PORT_W-1:0]    s_back_pixel,
    // result out
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [aod_pkg::OD_W-1:0]        m_od,
    output logic [aod_pkg::DISP_W-1:0]             m_display,
    output logic                                   m_invalid
);
    import aod_pkg::*;

    localparam int E_W   = $clog2(PIXEL_BITS);
    localparam int LOG_W = E_W + LOG_FRAC;          // log2 result width
    localparam int PW    = LOG_W + 32;              // product width
    localparam int RSH   = LOG_FRAC + 32 - OD_FRAC_BITS;
    localparam int RW    = PW + 1 - RSH;            // rounded magnitude width
    localparam int NW    = 26;                      // dividend width

    // stage map
    localparam int ST_A    = 0;                     // differences
    localparam int ST_LOG0 = 1;                     // normalize
    localparam int ST_C    = ST_LOG0 + LOG_FRAC + 1;// |lb - la|
    localparam int ST_D    = ST_C + 1;              // times ln2
    localparam int ST_E    = ST_D + 1;              // round, saturate
    localparam int ST_F    = ST_E + 1;              // rail offsets
    localparam int ST_DIV0 = ST_F + 1;              // dividend, flags
    localparam int ST_OUT  = ST_DIV0 + QBITS;       // last quotient bit, masking
    localparam int NST     = ST_OUT + 1;

    typedef struct packed {
        logic                   inv;
        logic                   ok;     // rail_up > rail_down
        logic                   pos;    // od above rail_down
        logic                   big;    // od at or above rail_up
        logic signed [OD_W-1:0] od;
    } dside_t;

    // ---------------------------------------------------------------
    // Config registers
    // ---------------------------------------------------------------
    logic signed [CFG_W-1:0] rail_down_reg, rail_up_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rail_down_reg <= RAIL_DOWN_RST;
            rail_up_reg   <= RAIL_UP_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_RAIL_DOWN) rail_down_reg <= cfg_wdata;
            if (cfg_index == REG_RAIL_UP)   rail_up_reg   <= cfg_wdata;
        end
    end

    // ---------------------------------------------------------------
    // Stage flow: a stage moves when it is empty or its successor moves,
    // so bubbles collapse and a stalled output still lets the front fill.
    // ---------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    always_comb begin
        en[NST-1] = !vld_reg[NST-1] || m_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (en[i]) vld_reg[i] <= (i == 0) ? s_valid : vld_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[ST_OUT];

    // ---------------------------------------------------------------
    // Stage A: background subtraction
    // ---------------------------------------------------------------
    logic [PIXEL_BITS-1:0] atom_w, beam_w, back_w;
    logic [PIXEL_BITS-1:0] a_d_reg, b_d_reg;
    logic                  inv_a_reg;

    assign atom_w = s_atom_pixel[PIXEL_BITS-1:0];
    assign beam_w = s_beam_pixel[PIXEL_BITS-1:0];
    assign back_w = s_back_pixel[PIXEL_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (en[ST_A]) begin
            a_d_reg   <= atom_w - back_w;
            b_d_reg   <= beam_w - back_w;
            inv_a_reg <= (beam_w <= back_w) || (atom_w <= back_w);
        end
    end

    // ---------------------------------------------------------------
    // Log2 units: normalize, then one squaring per stage for each bit
    // ---------------------------------------------------------------
    function automatic logic [E_W-1:0] msb_pos(input logic [PIXEL_BITS-1:0] x);
        logic [E_W-1:0] p;
        p = '0;
        for (int i = 0; i < PIXEL_BITS; i++) begin
            if (x[i]) p = E_W'(i);
        end
        return p;
    endfunction

    logic [LOG_W-1:0]  la_reg [0:LOG_FRAC];
    logic [LOG_W-1:0]  lb_reg [0:LOG_FRAC];
    logic [MANT_W-1:0] ma_reg [0:LOG_FRAC];
    logic [MANT_W-1:0] mb_reg [0:LOG_FRAC];
    logic              linv_reg [0:LOG_FRAC];

    logic [E_W-1:0] ea_w, eb_w;
    assign ea_w = msb_pos(a_d_reg);
    assign eb_w = msb_pos(b_d_reg);

    always_ff @(posedge aclk) begin
        if (en[ST_LOG0]) begin
            la_reg[0]   <= LOG_W'(ea_w);
            lb_reg[0]   <= LOG_W'(eb_w);
            ma_reg[0]   <= MANT_W'(a_d_reg) << (5'd31 - 5'(ea_w));
            mb_reg[0]   <= MANT_W'(b_d_reg) << (5'd31 - 5'(eb_w));
            linv_reg[0] <= inv_a_reg;
        end
    end

    for (genvar j = 1; j <= LOG_FRAC; j++) begin : g_sq
        logic [2*MANT_W-1:0] sqa, sqb;
        logic [MANT_W:0]     ta, tb;
        assign sqa = {{MANT_W{1'b0}}, ma_reg[j-1]} * {{MANT_W{1'b0}}, ma_reg[j-1]};
        assign sqb = {{MANT_W{1'b0}}, mb_reg[j-1]} * {{MANT_W{1'b0}}, mb_reg[j-1]};
        assign ta  = sqa[2*MANT_W-1:MANT_W-1];
        assign tb  = sqb[2*MANT_W-1:MANT_W-1];
        always_ff @(posedge aclk) begin
            if (en[ST_LOG0+j]) begin
                la_reg[j]   <= {la_reg[j-1][LOG_W-2:0], ta[MANT_W]};
                lb_reg[j]   <= {lb_reg[j-1][LOG_W-2:0], tb[MANT_W]};
                ma_reg[j]   <= ta[MANT_W] ? ta[MANT_W:1] : ta[MANT_W-1:0];
                mb_reg[j]   <= tb[MANT_W] ? tb[MANT_W:1] : tb[MANT_W-1:0];
                linv_reg[j] <= linv_reg[j-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stages C..E: difference, scale by ln2, round and saturate
    // ---------------------------------------------------------------
    logic [LOG_W-1:0] mag_reg;
    logic             neg_c_reg, inv_c_reg;
    logic [PW-1:0]    prod_reg;
    logic             neg_d_reg, inv_d_reg;
    logic signed [OD_W-1:0] od_e_reg;
    logic             inv_e_reg;

    logic [LOG_W-1:0] la_f, lb_f;
    assign la_f = la_reg[LOG_FRAC];
    assign lb_f = lb_reg[LOG_FRAC];

    always_ff @(posedge aclk) begin
        if (en[ST_C]) begin
            neg_c_reg <= la_f > lb_f;
            mag_reg   <= (la_f > lb_f) ? la_f - lb_f : lb_f - la_f;
            inv_c_reg <= linv_reg[LOG_FRAC];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_D]) begin
            prod_reg  <= PW'(mag_reg) * PW'(LN2_Q32);
            neg_d_reg <= neg_c_reg;
            inv_d_reg <= inv_c_reg;
        end
    end

    logic [PW:0]     rsum_w;
    logic [RW-1:0]   rmag_w;
    logic [31:0]     rmag32_w;
    logic signed [OD_W-1:0] od_w;

    always_comb begin
        rsum_w   = {1'b0, prod_reg} + ((PW+1)'(1) << (RSH - 1));
        rmag_w   = rsum_w[PW:RSH];
        rmag32_w = 32'(rmag_w);
        if (neg_d_reg) begin
            od_w = (rmag32_w > 32'd32768) ? 16'sh8000 : OD_W'(-rmag32_w);
        end else begin
            od_w = (rmag32_w > 32'd32767) ? 16'sh7fff : OD_W'(rmag32_w);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_E]) begin
            od_e_reg  <= od_w;
            inv_e_reg <= inv_d_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage F: rail offsets (user must change rails only while idle; unchecked)
    // ---------------------------------------------------------------
    logic signed [OD_W:0]   num_reg, den_reg;
    logic signed [OD_W-1:0] od_f_reg;
    logic                   inv_f_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_F]) begin
            num_reg   <= {od_e_reg[OD_W-1], od_e_reg} - {rail_down_reg[CFG_W-1], rail_down_reg};
            den_reg   <= {rail_up_reg[CFG_W-1], rail_up_reg}
                         - {rail_down_reg[CFG_W-1], rail_down_reg};
            od_f_reg  <= od_e_reg;
            inv_f_reg <= inv_e_reg;
        end
    end

    // ---------------------------------------------------------------
    // Display: q = (num*510 + den) / (2*den), one quotient bit a stage.
    // Only needed when 0 < num < den, so q fits 8 bits.
    // ---------------------------------------------------------------
    logic [NW-1:0]     rem_reg [0:QBITS-1];
    logic [OD_W:0]     d2_reg  [0:QBITS-1];
    logic [QBITS-1:0]  q_reg   [0:QBITS-1];
    dside_t            ds_reg  [0:QBITS-1];

    always_ff @(posedge aclk) begin
        if (en[ST_DIV0]) begin
            rem_reg[0] <= NW'(num_reg[OD_W-1:0]) * NW'(510) + NW'(den_reg[OD_W-1:0]);
            d2_reg[0]  <= {den_reg[OD_W-1:0], 1'b0};
            q_reg[0]   <= '0;
            ds_reg[0]  <= '{inv: inv_f_reg,
                            ok:  den_reg > 0,
                            pos: num_reg > 0,
                            big: num_reg >= den_reg,
                            od:  od_f_reg};
        end
    end

    for (genvar j = 1; j < QBITS; j++) begin : g_div
        logic [NW-1:0] sh;
        logic          qb;
        assign sh = NW'(d2_reg[j-1]) << (QBITS - j);
        assign qb = rem_reg[j-1] >= sh;
        always_ff @(posedge aclk) begin
            if (en[ST_DIV0+j]) begin
                rem_reg[j] <= qb ? rem_reg[j-1] - sh : rem_reg[j-1];
                d2_reg[j]  <= d2_reg[j-1];
                q_reg[j]   <= {q_reg[j-1][QBITS-2:0], qb};
                ds_reg[j]  <= ds_reg[j-1];
            end
        end
    end

    // output stage: last quotient bit and special cases
    logic             qb_last;
    logic [QBITS-1:0] q_last;
    dside_t           ds_last;
    logic signed [OD_W-1:0] od_out_reg;
    logic [DISP_W-1:0]      disp_reg;
    logic                   inv_out_reg;

    assign ds_last = ds_reg[QBITS-1];
    assign qb_last = rem_reg[QBITS-1] >= NW'(d2_reg[QBITS-1]);
    assign q_last  = {q_reg[QBITS-1][QBITS-2:0], qb_last};

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            inv_out_reg <= ds_last.inv;
            od_out_reg  <= ds_last.inv ? '0 : ds_last.od;
            priority if (ds_last.inv || !ds_last.ok || !ds_last.pos) begin
                disp_reg <= '0;
            end else if (ds_last.big) begin
                disp_reg <= '1;
            end else begin
                disp_reg <= DISP_W'(q_last);
            end
        end
    end

    assign m_od      = od_out_reg;
    assign m_display = disp_reg;
    assign m_invalid = inv_out_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_inv_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_invalid) |-> (m_od == 0 && m_display == 0))
        else $error("invalid result with nonzero od or display");

    a_rails_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (rail_up_reg <= rail_down_reg)) |-> (m_display == 0))
        else $error("display nonzero with inverted rails");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_od) && $stable(m_display)))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> (vld_reg == '0))
        else $error("stage valid bits not cleared by reset");

endmodule
`default_nettype wire

// ===== dv/absorption_optical_density_pixel_checker.sv =====
// Checker for the optical density pixel core: predicts each result and compares it.
// Depends on aod_pkg; watches the config port and both channels.
`timescale 1ns / 1ps
module absorption_optical_density_pixel_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [aod_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [aod_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                           s_valid,
    input  wire logic                           s_ready,
    input  wire logic [15:0]                    s_atom_pixel,
    input  wire logic [15:0]                    s_beam_pixel,
    input  wire logic [15:0]                    s_back_pixel,
    input  wire logic                           m_valid,
    input  wire logic                           m_ready,
    input  wire logic signed [15:0]             m_od,
    input  wire logic [7:0]                     m_display,
    input  wire logic                           m_invalid,
    output int                                  fail_count,
    output int                                  pending
);
    import aod_pkg::*;

    typedef struct packed {
        logic signed [15:0] od;
        logic [7:0]         disp;
        logic               inv;
    } od_result_t;

    localparam int FRAC = 11;

    logic signed [15:0] rail_lo, rail_hi;
    od_result_t         od_expected_q[$];

    // log2 with 28 fraction bits, truncated
    function automatic logic [63:0] log2_q28(input logic [15:0] x);
        logic [63:0] m, res;
        int e;
        e = 0;
        while (e < 15 && (x >> (e + 1)) != 0) e++;
        m = 64'(x) << (31 - e);
        res = 64'(e);
        for (int i = 0; i < 28; i++) begin
            m = (m * m) >> 31;
            res = res << 1;
            if (m >= 64'h1_0000_0000) begin
                res[0] = 1'b1;
                m = m >> 1;
            end
        end
        return res;
    endfunction

    function automatic od_result_t predict_od(input logic [15:0] atom, beam, back);
        od_result_t r;
        logic [63:0] la, lb, mag, prod, rmag, q;
        logic neg;
        int od, num, den;
        r = '0;
        if (beam <= back || atom <= back) begin
            r.inv = 1'b1;
            return r;
        end
        lb = log2_q28(beam - back);
        la = log2_q28(atom - back);
        neg = la > lb;
        mag = neg ? la - lb : lb - la;
        prod = mag * 64'(LN2_Q32);
        rmag = (prod + (64'd1 << (28 + 31 - FRAC))) >> (28 + 32 - FRAC);
        if (neg) od = (rmag > 32768) ? -32768 : -int'(rmag);
        else     od = (rmag > 32767) ? 32767 : int'(rmag);
        r.od = 16'(od);
        if (rail_hi > rail_lo) begin
            num = od - int'(rail_lo);
            den = int'(rail_hi) - int'(rail_lo);
            if (num > 0) begin
                q = (64'(num) * 510 + 64'(den)) / (64'(den) * 2);
                r.disp = (q > 255) ? 8'd255 : q[7:0];
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        od_result_t exp_r;
        if (!aresetn) begin
            rail_lo <= RAIL_DOWN_RST;
            rail_hi <= RAIL_UP_RST;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_RAIL_DOWN)    rail_lo <= cfg_wdata;
                else if (cfg_index == REG_RAIL_UP) rail_hi <= cfg_wdata;
            end
            if (s_valid && s_ready)
                od_expected_q.push_back(predict_od(s_atom_pixel, s_beam_pixel, s_back_pixel));
            if (m_valid && m_ready) begin
                if (od_expected_q.size() == 0) begin
                    $error("unexpected result transfer od=%0d", m_od);
                    fail_count++;
                end else begin
                    exp_r = od_expected_q.pop_front();
                    if (m_od !== exp_r.od) begin
                        $error("od: expected %0d, actual %0d", exp_r.od, m_od);
                        fail_count++;
                    end
                    if (m_display !== exp_r.disp) begin
                        $error("display: expected %0d, actual %0d", exp_r.disp, m_display);
                        fail_count++;
                    end
                    if (m_invalid !== exp_r.inv) begin
                        $error("invalid: expected %0d, actual %0d", exp_r.inv, m_invalid);
                        fail_count++;
                    end
                end
            end
        end
        pending = od_expected_q.size();
    end
endmodule

// ===== dv/absorption_optical_density_pixel_core_tb.sv =====
// Testbench top for the optical density pixel core: stimulus, rails and verdict.
// Depends on aod_pkg, the core and absorption_optical_density_pixel_checker.
`timescale 1ns / 1ps
module absorption_optical_density_pixel_core_tb;
    import aod_pkg::*;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [15:0]        s_atom_pixel = '0, s_beam_pixel = '0, s_back_pixel = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_od;
    logic [7:0]         m_display;
    logic               m_invalid;
    int                 fail_count, pending;

    // idle percentages for each side, changed per phase
    int src_idle_pct = 25;
    int sink_idle_pct = 46;

    always #5 aclk = ~aclk;

    absorption_optical_density_pixel_core dut (
        .aclk, .aresetn, .cfg_wr_en, .cfg_index, .cfg_wdata,
        .s_valid, .s_ready, .s_atom_pixel, .s_beam_pixel, .s_back_pixel,
        .m_valid, .m_ready, .m_od, .m_display, .m_invalid
    );

    absorption_optical_density_pixel_checker u_checker (
        .aclk, .aresetn, .cfg_wr_en, .cfg_index, .cfg_wdata,
        .s_valid, .s_ready, .s_atom_pixel, .s_beam_pixel, .s_back_pixel,
        .m_valid, .m_ready, .m_od, .m_display, .m_invalid,
        .fail_count, .pending
    );

    // receiver backpressure: random stalls at the current rate
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= sink_idle_pct);

    // one pixel triple transfer; random idle cycles come first, valid then
    // holds until the transfer edge
    task automatic send_pixel(input logic [15:0] atom, beam, back);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_atom_pixel <= atom;
        s_beam_pixel <= beam;
        s_back_pixel <= back;
        do @(posedge aclk); while (!s_ready);
    endtask

    // rails only change with the pipe empty: drain, then wait out the pipeline
    task automatic write_rail(input cfg_reg_t idx, input logic [15:0] val);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly well-formed triples with wide spread of magnitudes; some pure noise
    task automatic send_random_pixel();
        int back, atom, beam;
        if ($urandom_range(99) < 15) begin
            send_pixel(16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
            back = $urandom_range(65535) >> $urandom_range(16);
            atom = back + 1 + ($urandom_range(65535) >> $urandom_range(16));
            beam = back + 1 + ($urandom_range(65535) >> $urandom_range(16));
            if (atom > 65535) atom = 65535;
            if (beam > 65535) beam = 65535;
            send_pixel(16'(atom), 16'(beam), 16'(back));
        end
    endtask

    // rail pairs per random segment: full span, equal, inverted twice, narrow, -2048 .. 4096, random
    logic [15:0] rail_lo_set[7] = '{16'h8000, 16'd0, 16'd1000, 16'h7FFF, 16'd0,
                                   16'hF800, 16'd0};
    logic [15:0] rail_hi_set[7] = '{16'h7FFF, 16'd0, 16'hFC18, 16'h8000, 16'd1,
                                   16'd4096, 16'd0};

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset rails (0 .. 2048)
        send_pixel(16'd100, 16'd50, 16'd50);       // beam equal to back
        send_pixel(16'd50, 16'd100, 16'd50);       // atom equal to back
        send_pixel(16'd10, 16'd5, 16'd20);         // both below back
        send_pixel(16'd0, 16'd0, 16'd0);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'd1, 16'hFFFF, 16'd0);        // largest positive od
        send_pixel(16'hFFFF, 16'd1, 16'd0);        // largest negative od
        send_pixel(16'd1000, 16'd1000, 16'd0);     // od zero
        send_pixel(16'hFFFF, 16'hFFFE, 16'hFFFD);
        send_pixel(16'd1000, 16'd2718, 16'd0);     // about one: near rail_up
        send_pixel(16'd100, 16'd20000, 16'd0);     // above rail_up, clamps
        send_pixel(16'd20000, 16'd100, 16'd0);     // below rail_down, clamps
        send_pixel(16'h5555, 16'hAAAA, 16'h0001);
        send_pixel(16'hAAAA, 16'h5555, 16'h0000);
        send_pixel(16'h8000, 16'h7FFF, 16'h0000);
        send_pixel(16'h7FFF, 16'h8000, 16'h0001);

        // random segments, each under its own rails; idle profile by segment
        for (int seg = 0; seg < 7; seg++) begin
            if (seg == 6) begin
                write_rail(REG_RAIL_DOWN, 16'($urandom_range(65535)));
                write_rail(REG_RAIL_UP, 16'($urandom_range(65535)));
            end else begin
                write_rail(REG_RAIL_DOWN, rail_lo_set[seg]);
                write_rail(REG_RAIL_UP, rail_hi_set[seg]);
            end
            if ($urandom_range(3) == 0) write_rail(cfg_reg_t'(8'd2 + 8'($urandom_range(253))),
                                                   16'($urandom));
            if (seg == 2) begin
                src_idle_pct = 46;
                sink_idle_pct = 25;
            end else if (seg == 5) begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            repeat (250) send_random_pixel();
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end
endmodule

// ===== absorption_optical_density_pixel_core.f =====
rtl/core/aod_pkg.sv
rtl/core/absorption_optical_density_pixel_core.sv
dv/absorption_optical_density_pixel_checker.sv
dv/absorption_optical_density_pixel_core_tb.sv
